### hdl/tlpq_pkg.sv
// Shared constants, types and helper functions for the three-level priority queue.
`timescale 1ns / 1ps

package tlpq_pkg;

   localparam int MAX_DEPTH   = 8;
   localparam int VALUE_WIDTH = 32;
   localparam int NUM_LEVELS  = 3;

   localparam int PTR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
   localparam int CAP_W  = 4;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int LVL_W  = 2;
   localparam int ADDR_W = LVL_W + PTR_W;
   localparam int RAM_DEPTH = 1 << ADDR_W;
   localparam int IDX_W  = 2;
   localparam int STAT_W = 2;

   // Operation codes.
   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   // Priority levels.
   localparam logic [LVL_W-1:0] LVL_LOW  = 2'd0;
   localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
   localparam logic [LVL_W-1:0] LVL_HIGH = 2'd2;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] REG_HIGH_CAP = 2'd0;
   localparam logic [IDX_W-1:0] REG_MID_CAP  = 2'd1;
   localparam logic [IDX_W-1:0] REG_LOW_CAP  = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

   typedef struct packed {
      logic exec;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

   // A capacity of zero acts as one; anything above the ring size acts as the ring size.
   function automatic logic [CMP_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
      logic [CMP_W-1:0] cx;
      cx = CMP_W'(c);
      if (c == '0) begin
         return CMP_W'(1);
      end
      if (cx > CMP_W'(MAX_DEPTH)) begin
         return CMP_W'(MAX_DEPTH);
      end
      return cx;
   endfunction

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(MAX_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

endpackage

### hdl/three_level_priority_queue_top.sv
// Top level of the three-level strict-priority queue.
`timescale 1ns / 1ps

// Three FIFOs (low, medium, high) share one entry RAM; an enqueue item lands at
// the tail of its level, a dequeue item takes the oldest entry of the highest
// non-empty level, and every result carries a status and the empty and full
// masks after the operation. An item first updates pointers and counts and
// starts the RAM read, then loads the read data into the output register once it
// has room. A new item is taken as soon as that result has been registered, even
// while it still waits on rsp_stall; a stalled result only holds off the next
// item once it is itself ready to be registered. The user must write capacities
// through the csr port only while the queue is idle; it is not enforced.

module three_level_priority_queue_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic signed [tlpq_pkg::VALUE_WIDTH-1:0] req_item_value,
   input  logic [tlpq_pkg::LVL_W-1:0]             req_level,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [tlpq_pkg::STAT_W-1:0]            rsp_status,
   output logic signed [tlpq_pkg::VALUE_WIDTH-1:0] rsp_out_value,
   output logic [tlpq_pkg::NUM_LEVELS-1:0]        rsp_empty_mask,
   output logic [tlpq_pkg::NUM_LEVELS-1:0]        rsp_full_mask,
   input  logic                                   csr_wr_en,
   input  logic [tlpq_pkg::IDX_W-1:0]             csr_index,
   input  logic [tlpq_pkg::CAP_W-1:0]             csr_wdata
);

   tlpq_pkg::cmd_type  cmd;
   tlpq_pkg::stat_type stat;

   tlpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   tlpq_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req_func),
      .req_item_value (req_item_value),
      .req_level      (req_level),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_value  (rsp_out_value),
      .rsp_empty_mask (rsp_empty_mask),
      .rsp_full_mask  (rsp_full_mask)
   );

endmodule

### hdl/tlpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tlpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/tlpq_ctrl.sv
// Controller state machine that sequences one queue operation at a time.
`timescale 1ns / 1ps

module tlpq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  tlpq_pkg::stat_type stat,
   output logic               req_stall,
   output tlpq_pkg::cmd_type  cmd
);

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_DONE = 1'b1;

   logic [0:0] state_ff;
   logic [0:0] state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.exec     = 1'b0;
      cmd.load_out = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // The read data and updated flags are ready; wait for room in the output register.
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

### hdl/tlpq_dp.sv
// Datapath: ring pointers, occupancy counts, capacities, entry RAM and result register.
`timescale 1ns / 1ps

module tlpq_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tlpq_pkg::cmd_type                      cmd,
   output tlpq_pkg::stat_type                     stat,
   input  logic                                   req_func,
   input  logic signed [tlpq_pkg::VALUE_WIDTH-1:0] req_item_value,
   input  logic [tlpq_pkg::LVL_W-1:0]             req_level,
   input  logic                                   csr_wr_en,
   input  logic [tlpq_pkg::IDX_W-1:0]             csr_index,
   input  logic [tlpq_pkg::CAP_W-1:0]             csr_wdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [tlpq_pkg::STAT_W-1:0]            rsp_status,
   output logic signed [tlpq_pkg::VALUE_WIDTH-1:0] rsp_out_value,
   output logic [tlpq_pkg::NUM_LEVELS-1:0]        rsp_empty_mask,
   output logic [tlpq_pkg::NUM_LEVELS-1:0]        rsp_full_mask
);

   logic [tlpq_pkg::PTR_W-1:0] rd_ptr_ff [tlpq_pkg::NUM_LEVELS];
   logic [tlpq_pkg::PTR_W-1:0] rd_ptr_in [tlpq_pkg::NUM_LEVELS];
   logic [tlpq_pkg::PTR_W-1:0] wr_ptr_ff [tlpq_pkg::NUM_LEVELS];
   logic [tlpq_pkg::PTR_W-1:0] wr_ptr_in [tlpq_pkg::NUM_LEVELS];
   logic [tlpq_pkg::CNT_W-1:0] cnt_ff    [tlpq_pkg::NUM_LEVELS];
   logic [tlpq_pkg::CNT_W-1:0] cnt_in    [tlpq_pkg::NUM_LEVELS];
   logic [tlpq_pkg::CAP_W-1:0] cap_ff    [tlpq_pkg::NUM_LEVELS];
   logic [tlpq_pkg::CAP_W-1:0] cap_in    [tlpq_pkg::NUM_LEVELS];

   logic [tlpq_pkg::NUM_LEVELS-1:0] empty_vec;
   logic [tlpq_pkg::NUM_LEVELS-1:0] full_vec;
   logic [tlpq_pkg::NUM_LEVELS-1:0] enq_do;
   logic [tlpq_pkg::NUM_LEVELS-1:0] deq_do;
   logic [tlpq_pkg::NUM_LEVELS-1:0] lvl_sel;

   logic                              ram_wr_en;
   logic [tlpq_pkg::ADDR_W-1:0]       ram_wr_addr;
   logic                              ram_rd_en;
   logic [tlpq_pkg::ADDR_W-1:0]       ram_rd_addr;
   logic [tlpq_pkg::VALUE_WIDTH-1:0]  ram_rd_data;

   logic [tlpq_pkg::STAT_W-1:0] status_ff;
   logic [tlpq_pkg::STAT_W-1:0] status_in;
   logic                        deq_hit_ff;
   logic                        deq_hit_in;

   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic [tlpq_pkg::STAT_W-1:0]            rsp_status_ff;
   logic signed [tlpq_pkg::VALUE_WIDTH-1:0] rsp_value_ff;
   logic signed [tlpq_pkg::VALUE_WIDTH-1:0] rsp_value_in;
   logic [tlpq_pkg::NUM_LEVELS-1:0]        rsp_empty_ff;
   logic [tlpq_pkg::NUM_LEVELS-1:0]        rsp_full_ff;

   // Per-level flags from the current counts and capacities.
   always_comb begin
      for (int i = 0; i < tlpq_pkg::NUM_LEVELS; i++) begin
         empty_vec[i] = (cnt_ff[i] == '0);
         full_vec[i]  = (tlpq_pkg::CMP_W'(cnt_ff[i]) >= tlpq_pkg::eff_cap(cap_ff[i]));
      end
   end

   // Pick the level an item touches: the requested level for an enqueue, the
   // highest non-empty level for a dequeue.
   always_comb begin
      lvl_sel = '0;
      deq_do  = '0;
      enq_do  = '0;
      for (int i = 0; i < tlpq_pkg::NUM_LEVELS; i++) begin
         lvl_sel[i] = (req_level == tlpq_pkg::LVL_W'(i));
      end
      if (!empty_vec[tlpq_pkg::LVL_HIGH]) begin
         deq_do[tlpq_pkg::LVL_HIGH] = 1'b1;
      end else if (!empty_vec[tlpq_pkg::LVL_MID]) begin
         deq_do[tlpq_pkg::LVL_MID] = 1'b1;
      end else if (!empty_vec[tlpq_pkg::LVL_LOW]) begin
         deq_do[tlpq_pkg::LVL_LOW] = 1'b1;
      end
      if (!cmd.exec || req_func != tlpq_pkg::FUNC_DEQ) begin
         deq_do = '0;
      end
      if (cmd.exec && req_func == tlpq_pkg::FUNC_ENQ) begin
         enq_do = lvl_sel & ~full_vec;
      end
   end

   always_comb begin
      ram_wr_en   = |enq_do;
      ram_rd_en   = |deq_do;
      ram_wr_addr = '0;
      ram_rd_addr = '0;
      for (int i = 0; i < tlpq_pkg::NUM_LEVELS; i++) begin
         rd_ptr_in[i] = rd_ptr_ff[i];
         wr_ptr_in[i] = wr_ptr_ff[i];
         cnt_in[i]    = cnt_ff[i];
         if (enq_do[i]) begin
            ram_wr_addr  = {tlpq_pkg::LVL_W'(i), wr_ptr_ff[i]};
            wr_ptr_in[i] = tlpq_pkg::next_ptr(wr_ptr_ff[i]);
            cnt_in[i]    = cnt_ff[i] + tlpq_pkg::CNT_W'(1);
         end
         if (deq_do[i]) begin
            ram_rd_addr  = {tlpq_pkg::LVL_W'(i), rd_ptr_ff[i]};
            rd_ptr_in[i] = tlpq_pkg::next_ptr(rd_ptr_ff[i]);
            cnt_in[i]    = cnt_ff[i] - tlpq_pkg::CNT_W'(1);
         end
      end
   end

   always_comb begin
      status_in  = status_ff;
      deq_hit_in = deq_hit_ff;
      if (cmd.exec) begin
         status_in  = tlpq_pkg::ST_DONE;
         deq_hit_in = |deq_do;
         if (req_func == tlpq_pkg::FUNC_ENQ) begin
            if (|(lvl_sel & full_vec)) begin
               status_in = tlpq_pkg::ST_FULL;
            end
         end else if (!(|deq_do)) begin
            status_in = tlpq_pkg::ST_EMPTY;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < tlpq_pkg::NUM_LEVELS; i++) begin
         cap_in[i] = cap_ff[i];
      end
      if (csr_wr_en) begin
         case (csr_index)
            tlpq_pkg::REG_HIGH_CAP: cap_in[tlpq_pkg::LVL_HIGH] = csr_wdata;
            tlpq_pkg::REG_MID_CAP:  cap_in[tlpq_pkg::LVL_MID]  = csr_wdata;
            tlpq_pkg::REG_LOW_CAP:  cap_in[tlpq_pkg::LVL_LOW]  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tlpq_pkg::NUM_LEVELS; i++) begin
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
            cnt_ff[i]    <= '0;
            cap_ff[i]    <= tlpq_pkg::CAP_RESET;
         end
      end else begin
         for (int i = 0; i < tlpq_pkg::NUM_LEVELS; i++) begin
            rd_ptr_ff[i] <= rd_ptr_in[i];
            wr_ptr_ff[i] <= wr_ptr_in[i];
            cnt_ff[i]    <= cnt_in[i];
            cap_ff[i]    <= cap_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      deq_hit_ff <= deq_hit_in;
   end

   tlpq_ram #(
      .WIDTH (tlpq_pkg::VALUE_WIDTH),
      .DEPTH (tlpq_pkg::RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_item_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Output register.
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (status_ff == tlpq_pkg::ST_EMPTY) begin
         rsp_value_in = '1;
      end else if (deq_hit_ff) begin
         rsp_value_in = ram_rd_data;
      end else begin
         rsp_value_in = '0;
      end
      rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= rsp_value_in;
         rsp_empty_ff  <= empty_vec;
         rsp_full_ff   <= full_vec;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_value  = rsp_value_ff;
   assign rsp_empty_mask = rsp_empty_ff;
   assign rsp_full_mask  = rsp_full_ff;

endmodule
